[src/mne_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the metatile name-table expander.
// Used by the front end, the word queue and the back end; depends on nothing.
package mne_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_LAYOUT = 2'd0;
  localparam logic [1:0] OP_CHUNK  = 2'd1;
  localparam logic [1:0] OP_BLOCK  = 2'd2;
  localparam logic [1:0] OP_DRAW   = 2'd3;

  // Queue between front and back end.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Fields of a chunk-map word and of a layout byte.
  localparam int FLIP_LSB   = 11;
  localparam int BLOCK_BITS = 10;
  localparam int CHUNK_BITS = 7;

  // Shift used for the reciprocal in the plane wrap-around.
  localparam int RECIP_SHIFT = 24;

  // Byte step between horizontally adjacent name-table entries.
  localparam logic [15:0] COL_STEP = 16'd2;

  // One classified word as it travels from front end to back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] index;
    logic [15:0] value;
    logic        on_map;
    logic [10:0] layout_addr;
    logic [3:0]  tx;
    logic [3:0]  ty;
    logic [15:0] col_px;
    logic [15:0] row_px;
    logic [15:0] base;
  } entry_t;

endpackage

[src/mne_front.sv]
`timescale 1ns / 1ps
// Front end: takes command words, classifies them and prepares draw geometry.
// Depends on mne_pkg; feeds mne_queue.
module mne_front import mne_pkg::*; #(
  parameter int MAP_CHUNK_COLS = 64,
  parameter int MAP_CHUNK_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [14:0]        table_index,
  input  logic [15:0]        table_value,
  input  logic signed [15:0] scroll_x,
  input  logic signed [15:0] scroll_y,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic               layer,
  input  logic [15:0]        vram_base,
  input  logic               full,
  output logic               push,
  output entry_t             push_entry
);

  logic [15:0] wx;
  logic [15:0] wy;
  logic [16:0] vx;
  logic [16:0] vy;
  logic        keep;
  logic        accept;
  entry_t      cls;
  logic        f_valid;
  entry_t      f_entry;

  // Wrapped pixel position selects the chunk; the unwrapped sum selects the plane cell.
  always_comb begin
    wx = 16'(scroll_x + pos_x);
    wy = 16'(scroll_y + pos_y);
    vx = {scroll_x[15], scroll_x} + {pos_x[15], pos_x};
    vy = {scroll_y[15], scroll_y} + {pos_y[15], pos_y};
    cls.kind        = opcode;
    cls.index       = table_index;
    cls.value       = table_value;
    cls.on_map      = !wx[15] && ({1'b0, wx[14:8]} < 8'(MAP_CHUNK_COLS)) &&
                      !wy[15] && ({1'b0, wy[14:8]} < 8'(MAP_CHUNK_ROWS));
    cls.layout_addr = {layer, wy[10:8], wx[14:8]};
    cls.tx          = wx[7:4];
    cls.ty          = wy[7:4];
    cls.col_px      = {vx[16], vx[16:4], 2'b00};
    cls.row_px      = {vy[16], vy[16:4], 2'b00};
    cls.base        = vram_base;
  end

  // Loads beyond the end of their store have no effect and are dropped here.
  always_comb begin
    case (opcode)
      OP_LAYOUT: keep = (table_index[14:11] == 4'd0);
      OP_BLOCK:  keep = (table_index[14:12] == 3'd0);
      default:   keep = 1'b1;
    endcase
  end

  assign busy   = f_valid && full;
  assign accept = start && !busy;
  assign push   = f_valid && !full;
  assign push_entry = f_entry;

  // Single holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= (accept && keep) || (f_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      f_entry <= cls;
    end
  end

endmodule

[src/mne_queue.sv]
`timescale 1ns / 1ps
// Short first-in first-out queue of classified words between the two ends.
// Depends on mne_pkg.
module mne_queue import mne_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

[src/mne_back.sv]
`timescale 1ns / 1ps
// Back end: holds the three stores, performs loads and expands draws into four writes.
// Depends on mne_pkg; fed by mne_queue.
module mne_back import mne_pkg::*; #(
  parameter int PLANE_COLS = 64,
  parameter int PLANE_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        result_valid,
  output logic [15:0] vram_addr,
  output logic [15:0] tile_word,
  output logic        last
);

  localparam logic [15:0] COL_MOD   = 16'(2 * PLANE_COLS);
  localparam logic [15:0] ROW_MOD   = 16'(2 * PLANE_ROWS);
  localparam logic [15:0] ROW_PITCH = 16'(PLANE_COLS);
  localparam int unsigned COL_RECIP = (1 << RECIP_SHIFT) / (2 * PLANE_COLS);
  localparam int unsigned ROW_RECIP = (1 << RECIP_SHIFT) / (2 * PLANE_ROWS);
  localparam int COL_PW = 16 + $clog2(COL_RECIP + 1);
  localparam int ROW_PW = 16 + $clog2(ROW_RECIP + 1);

  // Stores.
  logic [7:0]  layout_mem [2048];
  logic [15:0] chunk_mem  [32768];
  logic [15:0] block_mem  [4096];

  // Stage 1: layout byte read, reciprocal products.
  logic              s1_valid;
  logic              s1_on_map;
  logic [3:0]        s1_tx;
  logic [3:0]        s1_ty;
  logic [15:0]       s1_base;
  logic [15:0]       s1_col_px;
  logic [15:0]       s1_row_px;
  logic [COL_PW-1:0] s1_col_prod;
  logic [ROW_PW-1:0] s1_row_prod;
  logic [7:0]        layout_rd;

  // Stage 2: chunk word read, raw remainders.
  logic        s2_valid;
  logic        s2_use_blk;
  logic [15:0] s2_base;
  logic [8:0]  s2_col_rem;
  logic [8:0]  s2_row_rem;
  logic [15:0] chunk_rd;

  // Stage 3: decoded chunk word, plane cell.
  logic                  s3_valid;
  logic [BLOCK_BITS-1:0] s3_blk;
  logic [1:0]            s3_flip;
  logic [15:0]           s3_base;
  logic [7:0]            s3_col;
  logic [7:0]            s3_row;

  // Stage 4: name-table byte address of the block.
  logic                  s4_valid;
  logic [BLOCK_BITS-1:0] s4_blk;
  logic [1:0]            s4_flip;
  logic [15:0]           s4_pos;

  // Emit stage: one block-store read per cycle.
  logic                  e_active;
  logic [1:0]            e_k;
  logic [BLOCK_BITS-1:0] e_blk;
  logic [1:0]            e_flip;
  logic [15:0]           e_pos;

  logic [15:0] block_rd;
  logic [1:0]  out_flip;

  logic e_free, s4_adv, s4_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
  logic pipe_empty, pop_draw, pop_load;

  logic [CHUNK_BITS-1:0] chunk_num;
  logic                  use_blk;
  logic [14:0]           chunk_addr;
  logic [15:0]           col_q, row_q, col_diff, row_diff, col_fix, row_fix;
  logic [15:0]           word_off;

  // Stage hand-over: each stage moves on when the next one is free.
  always_comb begin
    e_free     = !e_active || (e_k == 2'd3);
    s4_adv     = s4_valid && e_free;
    s4_free    = !s4_valid || s4_adv;
    s3_adv     = s3_valid && s4_free;
    s3_free    = !s3_valid || s3_adv;
    s2_adv     = s2_valid && s3_free;
    s2_free    = !s2_valid || s2_adv;
    s1_adv     = s1_valid && s2_free;
    s1_free    = !s1_valid || s1_adv;
    pipe_empty = !s1_valid && !s2_valid && !s3_valid && !s4_valid && !e_active;
    // Loads wait until every earlier draw has finished reading the stores.
    pop        = !empty && ((head.kind == OP_DRAW) ? s1_free : pipe_empty);
    pop_draw   = pop && (head.kind == OP_DRAW);
    pop_load   = pop && (head.kind != OP_DRAW);
  end

  // Layout store: loaded and read at queue pop.
  always_ff @(posedge clk) begin
    if (pop_load && (head.kind == OP_LAYOUT)) begin
      layout_mem[head.index[10:0]] <= head.value[7:0];
    end
    if (pop_draw) begin
      layout_rd <= layout_mem[head.layout_addr];
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (pop_draw) begin
      s1_on_map   <= head.on_map;
      s1_tx       <= head.tx;
      s1_ty       <= head.ty;
      s1_base     <= head.base;
      s1_col_px   <= head.col_px;
      s1_row_px   <= head.row_px;
      s1_col_prod <= COL_PW'(head.col_px) * COL_PW'(COL_RECIP);
      s1_row_prod <= ROW_PW'(head.row_px) * ROW_PW'(ROW_RECIP);
    end
  end

  // Chunk address and remainder estimate; off-map or empty chunks use word 0.
  always_comb begin
    chunk_num  = layout_rd[CHUNK_BITS-1:0];
    use_blk    = s1_on_map && (chunk_num != '0);
    chunk_addr = use_blk ? {chunk_num - 1'b1, s1_ty, s1_tx} : 15'd0;
    col_q      = 16'(s1_col_prod >> RECIP_SHIFT);
    row_q      = 16'(s1_row_prod >> RECIP_SHIFT);
    col_diff   = s1_col_px - 16'(col_q * COL_MOD);
    row_diff   = s1_row_px - 16'(row_q * ROW_MOD);
  end

  // Chunk store: loaded at queue pop, read as a draw leaves stage 1.
  always_ff @(posedge clk) begin
    if (pop_load && (head.kind == OP_CHUNK)) begin
      chunk_mem[head.index] <= head.value;
    end
    if (s1_adv) begin
      chunk_rd <= chunk_mem[chunk_addr];
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_use_blk <= use_blk;
      s2_base    <= s1_base;
      s2_col_rem <= col_diff[8:0];
      s2_row_rem <= row_diff[8:0];
    end
  end

  // The estimate is at most one short, so one conditional subtract finishes the wrap.
  always_comb begin
    col_fix = ({7'b0, s2_col_rem} >= COL_MOD) ? ({7'b0, s2_col_rem} - COL_MOD)
                                              : {7'b0, s2_col_rem};
    row_fix = ({7'b0, s2_row_rem} >= ROW_MOD) ? ({7'b0, s2_row_rem} - ROW_MOD)
                                              : {7'b0, s2_row_rem};
  end

  // Stage 3 payload.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_blk  <= s2_use_blk ? chunk_rd[BLOCK_BITS-1:0] : '0;
      s3_flip <= chunk_rd[FLIP_LSB +: 2];
      s3_base <= s2_base;
      s3_col  <= col_fix[7:0];
      s3_row  <= row_fix[7:0];
    end
  end

  // Stage 4 payload.
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s4_blk  <= s3_blk;
      s4_flip <= s3_flip;
      s4_pos  <= s3_base + 16'({8'b0, s3_row} * ROW_PITCH) + {8'b0, s3_col};
    end
  end

  // Stage valid bits and the emit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      e_active <= 1'b0;
      e_k      <= 2'd0;
    end else begin
      s1_valid <= pop_draw || (s1_valid && !s1_adv);
      s2_valid <= s1_adv || (s2_valid && !s2_adv);
      s3_valid <= s2_adv || (s3_valid && !s3_adv);
      s4_valid <= s3_adv || (s4_valid && !s4_adv);
      if (s4_adv) begin
        e_active <= 1'b1;
        e_k      <= 2'd0;
      end else if (e_active) begin
        e_active <= (e_k != 2'd3);
        e_k      <= e_k + 2'd1;
      end
    end
  end

  // Emit stage payload.
  always_ff @(posedge clk) begin
    if (s4_adv) begin
      e_blk  <= s4_blk;
      e_flip <= s4_flip;
      e_pos  <= s4_pos;
    end
  end

  // Flips swap the column and row halves of the 2x2 tile order.
  always_comb begin
    word_off = ((e_k[1] ^ e_flip[1]) ? COL_MOD : 16'd0) +
               ((e_k[0] ^ e_flip[0]) ? COL_STEP : 16'd0);
  end

  // Block store: loaded at queue pop, read once per emit cycle.
  always_ff @(posedge clk) begin
    if (pop_load && (head.kind == OP_BLOCK)) begin
      block_mem[head.index[11:0]] <= head.value;
    end
    if (e_active) begin
      block_rd <= block_mem[{e_blk, e_k}];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= e_active;
    end
  end

  always_ff @(posedge clk) begin
    if (e_active) begin
      vram_addr <= e_pos + word_off;
      last      <= (e_k == 2'd3);
      out_flip  <= e_flip;
    end
  end

  assign tile_word = block_rd ^ ({14'b0, out_flip} << FLIP_LSB);

  a_burst_whole: assert property (@(posedge clk) disable iff (rst)
      result_valid && last |-> $past(result_valid, 1) && $past(result_valid, 2) &&
                               $past(result_valid, 3))
    else $error("last word without three words before it");
  a_burst_runs: assert property (@(posedge clk) disable iff (rst)
      result_valid && !last |=> result_valid)
    else $error("word burst broken off before its last word");
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
      e_active && (e_k != 2'd3) |=> e_active && (e_k == $past(e_k) + 2'd1))
    else $error("emit counter skipped or stopped inside a block");
  a_load_isolated: assert property (@(posedge clk) disable iff (rst)
      pop_load |=> !s1_valid && !e_active)
    else $error("store load overlapped a draw in flight");

endmodule

[src/metatile_nametable_expander_top.sv]
`timescale 1ns / 1ps
// Top level of the metatile name-table expander: front end, queue and back end.
// Depends on mne_pkg, mne_front, mne_queue and mne_back.
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------------------------
//  command   start / busy              opcode table_index table_value scroll_x
//                                      scroll_y pos_x pos_y layer vram_base
//  result    result_valid (one cycle)  vram_addr tile_word last
//
// A word is taken each cycle while busy is low; busy rises only when the holding register
// and the four-entry queue are both full.
// A draw gives four results on consecutive cycles; the single block-store read port
// finishes one draw's words before the next, while later draws move up the stages.
// A load waits in the queue until every draw ahead of it has read its last block word.
// Synchronous reset clears only control; the stores hold nothing useful until loaded.
// The receiver cannot stall: every result is shown for exactly one cycle.
module metatile_nametable_expander_top import mne_pkg::*; #(
  parameter int PLANE_COLS     = 64,
  parameter int PLANE_ROWS     = 32,
  parameter int MAP_CHUNK_COLS = 64,
  parameter int MAP_CHUNK_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [14:0]        table_index,
  input  logic [15:0]        table_value,
  input  logic signed [15:0] scroll_x,
  input  logic signed [15:0] scroll_y,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic               layer,
  input  logic [15:0]        vram_base,
  output logic               result_valid,
  output logic [15:0]        vram_addr,
  output logic [15:0]        tile_word,
  output logic               last
);

  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  entry_t push_entry;
  entry_t head;

  // Command intake and classification.
  mne_front #(
    .MAP_CHUNK_COLS(MAP_CHUNK_COLS),
    .MAP_CHUNK_ROWS(MAP_CHUNK_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .table_index(table_index),
    .table_value(table_value),
    .scroll_x   (scroll_x),
    .scroll_y   (scroll_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .layer      (layer),
    .vram_base  (vram_base),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  mne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Stores and draw expansion.
  mne_back #(
    .PLANE_COLS(PLANE_COLS),
    .PLANE_ROWS(PLANE_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .vram_addr   (vram_addr),
    .tile_word   (tile_word),
    .last        (last)
  );

endmodule
